// ----- sv/hsl2rgb_pkg.sv -----
// Shared types and field widths for the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

    // Input field widths
    localparam int HUE_W   = 16;
    localparam int SAT_W   = 17;
    localparam int LIGHT_W = 17;
    localparam int IN_W    = HUE_W + SAT_W + LIGHT_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    // Output field widths
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int OUT_TDATA_W = CHAN_W * NUM_CHAN;

    // Segment of the piecewise hue ramp
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_FLAT,
        SEG_FALL,
        SEG_LOW
    } t_seg;

endpackage

`default_nettype wire

// ----- sv/hsl_to_rgb_converter.sv -----
// HSL to RGB colour converter, seven-stage pipeline.
`default_nettype none

// Converts one colour per item from hue, saturation and lightness (unsigned
// fractions with FRAC_BITS fraction bits; saturation and lightness above one
// are saturated to one, hue wraps) into 8-bit red, green and blue. A new item
// is accepted in every cycle while the output side takes results. The seven
// register stages, the first loaded at the edge that accepts an item, are:
// clamp, l*s product, q/p and hue shifts, ramp segment select, the
// per-channel ramp multiplier, ramp value sum, and the final scaling by
// 255 with rounding. Each stage advances on its own when the next one has
// room, so bubbles close up under a stall.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // hue [15:0], saturation [32:16], lightness [49:33], zero fill above
    input  wire logic [hsl2rgb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [hsl2rgb_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int FB    = FRAC_BITS;
    localparam int EXT_W = FB + 18;
    localparam int PW    = FB + 2;
    localparam int XW    = FB + 3;
    localparam int MW    = PW + XW;
    localparam int VW    = 2 * FB + 4;
    localparam int SW    = VW + 8;
    localparam int RW    = SW - 2 * FB;
    localparam int CW    = hsl2rgb_pkg::CHAN_W;
    localparam int NC    = hsl2rgb_pkg::NUM_CHAN;
    localparam int HW    = hsl2rgb_pkg::HUE_W;
    localparam int SAW   = hsl2rgb_pkg::SAT_W;
    localparam int LW    = hsl2rgb_pkg::LIGHT_W;
    localparam int unsigned ONE_I = 32'd1 << FB;

    localparam logic [FB:0]      ONE     = {1'b1, {FB{1'b0}}};
    localparam logic [FB:0]      HALF    = {2'b01, {(FB - 1){1'b0}}};
    localparam logic [FB-1:0]    THIRD   = FB'(ONE_I / 3);
    localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(ONE);
    localparam logic [XW-1:0]    ONE_X   = XW'(ONE);
    localparam logic [XW-1:0]    FOUR_X  = XW'(ONE) << 2;
    localparam logic [FB+1:0]    TWO_3   = (FB + 2)'(ONE) << 1;
    localparam logic [SW-1:0]    ROUND   = SW'(1) << (2 * FB - 1);
    localparam logic [RW-1:0]    MAX_B   = RW'(255);

    // Stage handshake: each stage loads when empty or when the next one loads
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic en1, en2, en3, en4, en5, en6, en7;

    always_comb begin
        en7 = !r_v7 || i_m_axis_tready;
        en6 = !r_v6 || en7;
        en5 = !r_v5 || en6;
        en4 = !r_v4 || en5;
        en3 = !r_v3 || en4;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
    end

    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r_v7;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
            if (en7) r_v7 <= r_v6;
        end
    end

    // ---------------- Stage 1: unpack, wrap hue, saturate s and l
    logic [FB+HW-1:0]  hue_ext;
    logic [EXT_W-1:0]  sat_ext, light_ext;
    logic [FB-1:0]     n1_h, r1_h;
    logic [FB:0]       n1_s, r1_s, n1_l, r1_l;

    always_comb begin
        hue_ext   = {{FB{1'b0}}, i_s_axis_tdata[HW-1:0]};
        sat_ext   = EXT_W'(i_s_axis_tdata[HW+SAW-1:HW]);
        light_ext = EXT_W'(i_s_axis_tdata[HW+SAW+LW-1:HW+SAW]);
        n1_h      = hue_ext[FB-1:0];
        n1_s      = (sat_ext > ONE_EXT) ? ONE : sat_ext[FB:0];
        n1_l      = (light_ext > ONE_EXT) ? ONE : light_ext[FB:0];
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_h <= n1_h;
            r1_s <= n1_s;
            r1_l <= n1_l;
        end
    end

    // ---------------- Stage 2: l*s product and grey value
    logic [2*FB+1:0]   ls_prod;
    logic [FB+8:0]     grey_prod;
    logic [FB:0]       n2_m, r2_m, r2_s, r2_l;
    logic [FB-1:0]     r2_h;
    logic [CW-1:0]     n2_grey, r2_grey;
    logic              n2_is_grey, r2_is_grey;

    always_comb begin
        ls_prod    = (2 * FB + 2)'(r1_l) * (2 * FB + 2)'(r1_s);
        n2_m       = ls_prod[2*FB:FB];
        grey_prod  = ({r1_l, 8'd0} - (FB + 9)'(r1_l));
        n2_grey    = grey_prod[FB+8] ? {CW{1'b1}} : grey_prod[FB+7:FB];
        n2_is_grey = (r1_s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_m       <= n2_m;
            r2_s       <= r1_s;
            r2_l       <= r1_l;
            r2_h       <= r1_h;
            r2_grey    <= n2_grey;
            r2_is_grey <= n2_is_grey;
        end
    end

    // ---------------- Stage 3: q, p and the three shifted hues
    logic [PW-1:0]     q_lo, q_hi, q_sel, two_l, n3_p, n3_q, r3_p, r3_q;
    logic [FB:0]       h_plus;
    logic [FB-1:0]     n3_t [NC];
    logic [FB-1:0]     r3_t [NC];
    logic [CW-1:0]     r3_grey;
    logic              r3_is_grey;

    always_comb begin
        q_lo  = PW'(r2_l) + PW'(r2_m);
        q_hi  = PW'(r2_l) + PW'(r2_s) - PW'(r2_m);
        q_sel = (r2_l <= HALF) ? q_lo : q_hi;
        two_l = {r2_l, 1'b0};
        n3_p  = (two_l >= q_sel) ? (two_l - q_sel) : '0;
        n3_q  = (q_sel < n3_p) ? n3_p : q_sel;
        // Red at hue plus a third, blue at hue minus a third, both wrapped
        h_plus  = {1'b0, r2_h} + {1'b0, THIRD};
        n3_t[0] = h_plus[FB-1:0];
        n3_t[1] = r2_h;
        n3_t[2] = r2_h - THIRD;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_p       <= n3_p;
            r3_q       <= n3_q;
            r3_t       <= n3_t;
            r3_grey    <= r2_grey;
            r3_is_grey <= r2_is_grey;
        end
    end

    // ---------------- Stage 4: pick ramp segment and multiplier operands
    logic [XW-1:0]          t6   [NC];
    logic [FB+1:0]          t3   [NC];
    hsl2rgb_pkg::t_seg      n4_seg [NC];
    hsl2rgb_pkg::t_seg      r4_seg [NC];
    logic [XW-1:0]          n4_x [NC];
    logic [XW-1:0]          r4_x [NC];
    logic [PW-1:0]          r4_d, r4_p, r4_q;
    logic [CW-1:0]          r4_grey;
    logic                   r4_is_grey;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            t3[c] = {1'b0, r3_t[c], 1'b0} + (FB + 2)'(r3_t[c]);
            t6[c] = {t3[c], 1'b0};
            priority if (t6[c] < ONE_X) begin
                n4_seg[c] = hsl2rgb_pkg::SEG_RISE;
                n4_x[c]   = t6[c];
            end else if (!r3_t[c][FB-1]) begin
                n4_seg[c] = hsl2rgb_pkg::SEG_FLAT;
                n4_x[c]   = '0;
            end else if (t3[c] < TWO_3) begin
                n4_seg[c] = hsl2rgb_pkg::SEG_FALL;
                n4_x[c]   = FOUR_X - t6[c];
            end else begin
                n4_seg[c] = hsl2rgb_pkg::SEG_LOW;
                n4_x[c]   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_seg     <= n4_seg;
            r4_x       <= n4_x;
            r4_d       <= r3_q - r3_p;
            r4_p       <= r3_p;
            r4_q       <= r3_q;
            r4_grey    <= r3_grey;
            r4_is_grey <= r3_is_grey;
        end
    end

    // ---------------- Stage 5: ramp slope product per channel
    logic [MW-1:0]          n5_prod [NC];
    logic [MW-1:0]          r5_prod [NC];
    hsl2rgb_pkg::t_seg      r5_seg  [NC];
    logic [PW-1:0]          r5_p, r5_q;
    logic [CW-1:0]          r5_grey;
    logic                   r5_is_grey;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n5_prod[c] = MW'(r4_d) * MW'(r4_x[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_prod    <= n5_prod;
            r5_seg     <= r4_seg;
            r5_p       <= r4_p;
            r5_q       <= r4_q;
            r5_grey    <= r4_grey;
            r5_is_grey <= r4_is_grey;
        end
    end

    // ---------------- Stage 6: ramp value with 2*FB fraction bits
    logic [VW-1:0]     n6_v [NC];
    logic [VW-1:0]     r6_v [NC];
    logic [VW-1:0]     p_wide, q_wide;
    logic [CW-1:0]     r6_grey;
    logic              r6_is_grey;

    always_comb begin
        p_wide = VW'(r5_p) << FB;
        q_wide = VW'(r5_q) << FB;
        for (int c = 0; c < NC; c++) begin
            unique case (r5_seg[c])
                hsl2rgb_pkg::SEG_RISE,
                hsl2rgb_pkg::SEG_FALL: n6_v[c] = p_wide + VW'(r5_prod[c]);
                hsl2rgb_pkg::SEG_FLAT: n6_v[c] = q_wide;
                hsl2rgb_pkg::SEG_LOW:  n6_v[c] = p_wide;
                default:               n6_v[c] = p_wide;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_v       <= n6_v;
            r6_grey    <= r5_grey;
            r6_is_grey <= r5_is_grey;
        end
    end

    // ---------------- Stage 7: scale by 255, round, clamp, pick grey
    logic [SW-1:0]     scaled [NC];
    logic [RW-1:0]     byte_w [NC];
    logic [CW-1:0]     chan   [NC];
    logic [hsl2rgb_pkg::OUT_TDATA_W-1:0] n7_data, r7_data;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            scaled[c] = {r6_v[c], 8'd0} - SW'(r6_v[c]) + ROUND;
            byte_w[c] = scaled[c][SW-1:2*FB];
            chan[c]   = (byte_w[c] > MAX_B) ? {CW{1'b1}} : byte_w[c][CW-1:0];
        end
        if (r6_is_grey) begin
            n7_data = {r6_grey, r6_grey, r6_grey};
        end else begin
            n7_data = {chan[2], chan[1], chan[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_data <= n7_data;
        end
    end

    assign o_m_axis_tdata = r7_data;

endmodule

`default_nettype wire

// ----- sv/hsl2rgb_checker.sv -----
// Port-level checks for the HSL to RGB converter, bound to its top level.
`default_nettype none

module hsl2rgb_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_s_axis_tvalid,
    input wire logic                                o_s_axis_tready,
    input wire logic [hsl2rgb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input wire logic                                o_m_axis_tvalid,
    input wire logic                                i_m_axis_tready,
    input wire logic [hsl2rgb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Hold a result that waits on the output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    // Drop valid only after a taken result
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_m_axis_tvalid) |-> $past(i_m_axis_tready))
        else $error("output item lost");

    // A free output side never throttles the input
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled with output ready");

    // An empty output register means the pipeline has room
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with no result pending");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_m_axis_tvalid)
        else $error("result present after reset");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
